[src/ppq_pkg.sv]
// Shared types and codes for the preemptive priority task queue.
package ppq_pkg;

   // Request codes
   localparam logic [1:0] REQ_ADD      = 2'd0;
   localparam logic [1:0] REQ_DISPATCH = 2'd1;
   localparam logic [1:0] REQ_COMPLETE = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_QUEUED  = 3'd0;
   localparam logic [2:0] ST_GRANTED = 3'd1;
   localparam logic [2:0] ST_NOTHING = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_NOSAVED = 3'd4;

   localparam logic [7:0] IDLE_LEVEL = 8'hFF;
   localparam int         COUNT_W    = 5;
   localparam int         ENTRY_W    = 16;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] task_handle;
      logic [7:0] priority_req;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         grant_handle;
      logic [7:0]         running_level;
      logic [COUNT_W-1:0] pending_count;
   } rsp_item_type;

   // One queue slot: handle above level
   typedef struct packed {
      logic [7:0] handle;
      logic [7:0] level;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic       latch;
      logic       ins_start;
      logic       ins_rd;
      logic       ins_move;
      logic       ins_place;
      logic       grant;
      logic       pop;
      logic       set_status;
      logic [2:0] status;
      logic       load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] req_code;
      logic       q_full;
      logic       q_empty;
      logic       nest_full;
      logic       nest_empty;
      logic       head_ok;
      logic       scan_done;
      logic       move_needed;
      logic       rsp_free;
   } stat_type;

endpackage

[src/preemptive_priority_task_queue.sv]
// Top level of the preemptive priority task queue.
//
// Requests arrive on the req_ channel (valid/stall), one transaction each:
// add a task, dispatch the most urgent task, or complete the running task.
// Every request yields exactly one result transaction on the rsp_ channel.
// An add walks the queue memory backward from the tail, one read and one
// write of the single-port-pair RAM per queued entry of a higher level that
// the new task passes; dispatch, complete and rejected requests need no scan.
// One request is in flight at a time; req_stall is high from acceptance until
// the result is loaded into the output register, and the next request can be
// taken in the cycle after that load.
// The result register lets the next request be taken while a result waits.
// If the receiver stalls with a result held, a finished request waits in the
// controller until the register frees. Synchronous reset empties the queue,
// clears the nesting stack and sets the running level to idle (255); no
// memory clearing pass is needed.
module preemptive_priority_task_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int NEST_DEPTH  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ppq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ppq_pkg::rsp_item_type rsp_item
);

   ppq_pkg::cmd_type  cmd;
   ppq_pkg::stat_type stat;

   ppq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ppq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NEST_DEPTH  (NEST_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .stat      (stat)
   );

`ifndef SYNTHESIS
   // One request at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   // Grant handle is zero unless granted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != ppq_pkg::ST_GRANTED)) |->
         (rsp_item.grant_handle == 8'd0))
      else $error("grant handle set on a result that is not a grant");

   // Grant only a ready, more urgent head with room to nest
   assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> (stat.head_ok && !stat.nest_full && !stat.q_empty))
      else $error("dispatch granted without a ready head");

   // Insert never into a full queue
   assert property (@(posedge clock) disable iff (reset)
      cmd.ins_start |-> !stat.q_full)
      else $error("insertion started on a full queue");
`endif

endmodule

[src/ppq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ppq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ppq_ctrl.sv]
// Controller state machine for the preemptive priority task queue.
module ppq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppq_pkg::stat_type stat,
   output ppq_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_DECODE  = 6'b000010,
      S_INS_RD  = 6'b000100,
      S_INS_CMP = 6'b001000,
      S_REPLY   = 6'b010000,
      S_SPARE   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Take a new transaction only while idle
   assign req_stall = (state_ff != S_IDLE);

   // Sequence each request
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_status = 1'b1;
            state_in       = S_REPLY;
            case (stat.req_code)
               ppq_pkg::REQ_ADD: begin
                  if (stat.q_full) begin
                     cmd.status = ppq_pkg::ST_FULL;
                  end else begin
                     cmd.set_status = 1'b0;
                     cmd.ins_start  = 1'b1;
                     state_in       = S_INS_RD;
                  end
               end
               ppq_pkg::REQ_DISPATCH: begin
                  if (stat.q_empty || stat.nest_full || !stat.head_ok) begin
                     cmd.status = ppq_pkg::ST_NOTHING;
                  end else begin
                     cmd.status = ppq_pkg::ST_GRANTED;
                     cmd.grant  = 1'b1;
                  end
               end
               ppq_pkg::REQ_COMPLETE: begin
                  if (stat.nest_empty) begin
                     cmd.status = ppq_pkg::ST_NOSAVED;
                  end else begin
                     cmd.status = ppq_pkg::ST_QUEUED;
                     cmd.pop    = 1'b1;
                  end
               end
               default: begin
                  cmd.status = ppq_pkg::ST_NOTHING;
               end
            endcase
         end
         S_INS_RD: begin
            if (stat.scan_done) begin
               cmd.ins_place  = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ppq_pkg::ST_QUEUED;
               state_in       = S_REPLY;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (stat.move_needed) begin
               cmd.ins_move = 1'b1;
               state_in     = S_INS_RD;
            end else begin
               cmd.ins_place  = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ppq_pkg::ST_QUEUED;
               state_in       = S_REPLY;
            end
         end
         S_REPLY: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/ppq_dpath.sv]
// Datapath: circular sorted queue, level stack, counters and result register.
module ppq_dpath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int NEST_DEPTH  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ppq_pkg::req_item_type req_item,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output ppq_pkg::rsp_item_type rsp_item,
   input  ppq_pkg::cmd_type      cmd,
   output ppq_pkg::stat_type     stat
);

   localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SA_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int SC_W = $clog2(NEST_DEPTH + 1);

   ppq_pkg::req_item_type req_ff;
   logic [QA_W-1:0]       head_ff;
   logic [QA_W-1:0]       head_in;
   logic [QC_W-1:0]       count_ff;
   logic [QC_W-1:0]       count_in;
   logic [SC_W-1:0]       depth_ff;
   logic [SC_W-1:0]       depth_in;
   logic [7:0]            level_ff;
   logic [7:0]            level_in;
   logic [QA_W-1:0]       hole_ff;
   logic [QA_W-1:0]       hole_in;
   logic [QC_W-1:0]       left_ff;
   logic [QC_W-1:0]       left_in;
   logic [2:0]            status_ff;
   logic [7:0]            grant_ff;
   logic                  rsp_valid_ff;
   ppq_pkg::rsp_item_type rsp_ff;

   logic [QA_W:0]         tail_sum;
   logic [QA_W-1:0]       tail_idx;
   logic [QA_W-1:0]       hole_prev;
   logic [SC_W-1:0]       depth_dec;
   logic [QA_W-1:0]       q_raddr;
   logic                  q_wen;
   ppq_pkg::entry_type    q_wdata;
   ppq_pkg::entry_type    q_rdata;
   logic [7:0]            s_rdata;

   // Physical slot after the last entry
   always_comb begin
      tail_sum = {1'b0, head_ff} + (QA_W + 1)'(count_ff);
      if (tail_sum >= (QA_W + 1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (QA_W + 1)'(QUEUE_DEPTH);
      end
      tail_idx = tail_sum[QA_W-1:0];
   end

   assign hole_prev = (hole_ff == '0) ? QA_W'(QUEUE_DEPTH - 1) : hole_ff - 1'b1;
   assign depth_dec = depth_ff - 1'b1;

   // Queue memory: read the slot below the hole while scanning, else the head
   assign q_raddr = cmd.ins_rd ? hole_prev : head_ff;
   assign q_wen   = cmd.ins_move | cmd.ins_place;
   assign q_wdata = cmd.ins_move ? q_rdata :
                    ppq_pkg::entry_type'({req_ff.task_handle, req_ff.priority_req});

   ppq_ram #(
      .WIDTH (ppq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wen),
      .wr_addr (hole_ff),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   // Saved level stack: push at the depth, always read the top
   ppq_ram #(
      .WIDTH (8),
      .DEPTH (NEST_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (cmd.grant),
      .wr_addr (depth_ff[SA_W-1:0]),
      .wr_data (level_ff),
      .rd_addr (depth_dec[SA_W-1:0]),
      .rd_data (s_rdata)
   );

   // Status toward the controller
   always_comb begin
      stat.req_code    = req_ff.req_type;
      stat.q_full      = (count_ff == QC_W'(QUEUE_DEPTH));
      stat.q_empty     = (count_ff == '0);
      stat.nest_full   = (depth_ff == SC_W'(NEST_DEPTH));
      stat.nest_empty  = (depth_ff == '0);
      stat.head_ok     = (q_rdata.level < level_ff);
      stat.scan_done   = (left_ff == '0);
      stat.move_needed = (q_rdata.level > req_ff.priority_req);
      stat.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   // Next values of the control state
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      depth_in = depth_ff;
      level_in = level_ff;
      hole_in  = hole_ff;
      left_in  = left_ff;
      if (cmd.ins_start) begin
         hole_in = tail_idx;
         left_in = count_ff;
      end
      if (cmd.ins_move) begin
         hole_in = hole_prev;
         left_in = left_ff - 1'b1;
      end
      if (cmd.ins_place) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.grant) begin
         head_in  = (head_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
         depth_in = depth_ff + 1'b1;
         level_in = q_rdata.level;
      end
      if (cmd.pop) begin
         depth_in = depth_dec;
         level_in = s_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         depth_ff     <= '0;
         level_ff     <= ppq_pkg::IDLE_LEVEL;
         hole_ff      <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         depth_ff <= depth_in;
         level_ff <= level_in;
         hole_ff  <= hole_in;
         left_ff  <= left_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request, the outcome and the result transaction
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff   <= req_item;
         grant_ff <= '0;
      end else if (cmd.grant) begin
         grant_ff <= q_rdata.handle;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.grant_handle  <= grant_ff;
         rsp_ff.running_level <= level_ff;
         rsp_ff.pending_count <= (ppq_pkg::COUNT_W)'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
